// ===== rtl/core/ept_pkg.sv =====
package ept_pkg;

    localparam int FRAC_BITS = 8;

    localparam int OP_W    = 2;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int SPEED_W = 33;
    localparam int CFG_W   = 16;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 1'd1;

    localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam longint RPM_SCALE       = 60000000;
    localparam int     EDGES_PER_COUNT = 2;
    localparam int     EDGE_SHIFT      = $clog2(EDGES_PER_COUNT);
    localparam logic [TIME_W-1:0] US_PER_MS = 32'd1000;

    localparam int NUM_W     = $clog2(RPM_SCALE + 1) + FRAC_BITS;
    localparam int PROD_W    = TIME_W + CFG_W;
    localparam int DEN_W     = PROD_W + EDGE_SHIFT;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [NUM_W-1:0]   SPEED_NUM = NUM_W'(RPM_SCALE) << FRAC_BITS;
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    localparam logic [CFG_W-1:0]  CPR_RESET     = 16'd500;
    localparam logic [CFG_W-1:0]  TIMEOUT_RESET = 16'd200;
    localparam logic [TIME_W-1:0] LIMIT_RESET   = TIME_W'(TIMEOUT_RESET) * US_PER_MS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_SHOW,
        CMD_SPEED,
        CMD_TICK,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [TIME_W-1:0]  now_us;
        logic [TIME_W-1:0]  interval;
        logic [COUNT_W-1:0] edge_count;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/core/ept_front.sv =====
module ept_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ept_pkg::OP_W-1:0]    s_operation,
    input  logic [ept_pkg::TIME_W-1:0]  s_now_us,
    output logic                        push_valid,
    input  logic                        push_ready,
    output ept_pkg::cmd_t               push_cmd
);
    import ept_pkg::*;

    logic [COUNT_W-1:0] edge_total_reg, edge_total_next;
    logic [TIME_W-1:0]  prev_edge_reg, prev_edge_next;
    logic [TIME_W-1:0]  interval;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        interval        = s_now_us - prev_edge_reg;
        edge_total_next = edge_total_reg;
        prev_edge_next  = prev_edge_reg;
        push_cmd.kind       = CMD_SHOW;
        push_cmd.now_us     = s_now_us;
        push_cmd.interval   = interval;
        push_cmd.edge_count = edge_total_reg;
        case (s_operation)
            OP_EDGE: begin
                edge_total_next     = edge_total_reg + COUNT_W'(1);
                prev_edge_next      = s_now_us;
                push_cmd.edge_count = edge_total_next;
                if (prev_edge_reg != '0 && interval != '0) begin
                    push_cmd.kind = CMD_SPEED;
                end
            end
            OP_TICK: begin
                push_cmd.kind = CMD_TICK;
            end
            OP_CLEAR: begin
                edge_total_next     = '0;
                prev_edge_next      = '0;
                push_cmd.kind       = CMD_CLEAR;
                push_cmd.edge_count = '0;
            end
            default: begin
                push_cmd.kind = CMD_SHOW;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_total_reg <= '0;
            prev_edge_reg  <= '0;
        end else if (s_valid && push_ready) begin
            edge_total_reg <= edge_total_next;
            prev_edge_reg  <= prev_edge_next;
        end
    end

endmodule

// ===== rtl/core/ept_queue.sv =====
module ept_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  ept_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ept_pkg::cmd_t pop_data
);
    import ept_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push_fire, pop_fire;

    assign push_ready = count_reg < QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                entry_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/ept_divider.sv =====
module ept_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ept_pkg::DEN_W-1:0]  divisor,
    output ept_pkg::div_status_t       status,
    output logic [ept_pkg::NUM_W-1:0]  quotient
);
    import ept_pkg::*;

    logic [DEN_W-1:0]     divisor_reg;
    logic [NUM_W-1:0]     rem_reg, quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [NUM_W:0]       trial;
    logic [DEN_W-1:0]     trial_ext, diff;
    logic                 fits;

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;

    always_comb begin
        trial     = {rem_reg, SPEED_NUM[cnt_reg]};
        trial_ext = DEN_W'(trial);
        diff      = trial_ext - divisor_reg;
        fits      = trial_ext >= divisor_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quot_reg    <= '0;
            cnt_reg     <= DIV_CNT_W'(NUM_W - 1);
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/ept_back.sv =====
module ept_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ept_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  ept_pkg::cmd_t                 pop_data,
    output logic                          div_start,
    output logic [ept_pkg::DEN_W-1:0]     div_divisor,
    input  ept_pkg::div_status_t          div_status,
    input  logic [ept_pkg::NUM_W-1:0]     div_quotient,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ept_pkg::SPEED_W-1:0]   m_speed_rpm_fx,
    output logic [ept_pkg::COUNT_W-1:0]   m_edge_count,
    output logic [ept_pkg::TIME_W-1:0]    m_interval_us
);
    import ept_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   cpr_reg;
    logic [TIME_W-1:0]  limit_reg;
    cmd_t               cmd_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               div_start_reg;
    logic               m_valid_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [COUNT_W-1:0] pulse_reg;
    logic [TIME_W-1:0]  period_reg;
    logic [TIME_W-1:0]  last_update_reg;

    logic               out_free;
    logic [TIME_W-1:0]  elapsed;
    logic [PROD_W-1:0]  product;
    logic [SPEED_W-1:0] speed_sat;

    assign out_free       = !m_valid_reg || m_ready;
    assign pop_ready      = (state_reg == S_IDLE) && out_free;
    assign div_start      = div_start_reg;
    assign div_divisor    = den_reg;
    assign m_valid        = m_valid_reg;
    assign m_speed_rpm_fx = speed_reg;
    assign m_edge_count   = pulse_reg;
    assign m_interval_us  = period_reg;

    always_comb begin
        elapsed   = pop_data.now_us - last_update_reg;
        product   = PROD_W'(cmd_reg.interval) * PROD_W'(cpr_reg);
        speed_sat = (64'(div_quotient) > 64'(SPEED_MAX)) ? SPEED_MAX
                                                          : SPEED_W'(div_quotient);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cpr_reg         <= CPR_RESET;
            limit_reg       <= LIMIT_RESET;
            div_start_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            speed_reg       <= '0;
            pulse_reg       <= '0;
            period_reg      <= '0;
            last_update_reg <= '0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COUNTS_PER_REV: cpr_reg   <= cfg_data;
                    CFG_TIMEOUT_MS:     limit_reg <= TIME_W'(cfg_data) * US_PER_MS;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (pop_valid && out_free) begin
                        case (pop_data.kind)
                            CMD_SPEED: begin
                                cmd_reg   <= pop_data;
                                state_reg <= S_MUL;
                            end
                            CMD_TICK: begin
                                pulse_reg   <= pop_data.edge_count;
                                m_valid_reg <= 1'b1;
                                if (last_update_reg != '0 && elapsed >= limit_reg) begin
                                    speed_reg       <= '0;
                                    last_update_reg <= '0;
                                end
                            end
                            CMD_CLEAR: begin
                                pulse_reg       <= '0;
                                speed_reg       <= '0;
                                period_reg      <= '0;
                                last_update_reg <= '0;
                                m_valid_reg     <= 1'b1;
                            end
                            default: begin
                                pulse_reg   <= pop_data.edge_count;
                                m_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    den_reg       <= DEN_W'(product) << EDGE_SHIFT;
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIV;
                end
                S_DIV: begin
                    if (!div_start_reg && div_status.done && out_free) begin
                        speed_reg       <= speed_sat;
                        period_reg      <= cmd_reg.interval;
                        last_update_reg <= cmd_reg.now_us;
                        pulse_reg       <= cmd_reg.edge_count;
                        m_valid_reg     <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/encoder_period_tachometer.sv =====
// A tick, a clear or an edge without a new period passes the queue and the result register;
// a period measurement passes the queue, the command, divisor and divider registers and then
// the result register. Throughput: one item per cycle while the queue has room and the result
// register is free, except that each period measurement holds the back end until the
// bit-serial divider, taking one quotient bit per cycle, is done. Reset: synchronous, active
// low; control state and outputs clear, counts_per_rev returns to 500 and timeout_ms to 200.
module encoder_period_tachometer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ept_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ept_pkg::OP_W-1:0]      s_operation,
    input  logic [ept_pkg::TIME_W-1:0]    s_now_us,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ept_pkg::SPEED_W-1:0]   m_speed_rpm_fx,
    output logic [ept_pkg::COUNT_W-1:0]   m_edge_count,
    output logic [ept_pkg::TIME_W-1:0]    m_interval_us
);
    import ept_pkg::*;

    logic             q_push_valid, q_push_ready;
    cmd_t             q_push_cmd;
    logic             q_pop_valid, q_pop_ready;
    cmd_t             q_pop_cmd;
    logic             div_start;
    logic [DEN_W-1:0] div_divisor;
    div_status_t      div_status;
    logic [NUM_W-1:0] div_quotient;

    ept_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_now_us    (s_now_us),
        .push_valid  (q_push_valid),
        .push_ready  (q_push_ready),
        .push_cmd    (q_push_cmd)
    );

    ept_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_cmd),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_cmd)
    );

    ept_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    ept_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pop_valid      (q_pop_valid),
        .pop_ready      (q_pop_ready),
        .pop_data       (q_pop_cmd),
        .div_start      (div_start),
        .div_divisor    (div_divisor),
        .div_status     (div_status),
        .div_quotient   (div_quotient),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_speed_rpm_fx (m_speed_rpm_fx),
        .m_edge_count   (m_edge_count),
        .m_interval_us  (m_interval_us)
    );

    // The divider is only started when it is not already working on a period.
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    // A finished division must follow a running one.
    a_div_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(div_status.done) |-> $past(div_status.busy))
        else $error("divider finished without running");

    // The back end takes a command only when the result register can be refilled.
    a_pop_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop_valid && q_pop_ready) |-> (!m_valid || m_ready))
        else $error("command taken while result register is blocked");

endmodule
